// ===== design/cbf_pkg.sv =====
// Shared types, action codes and helpers for the circular bit FIFO.
package cbf_pkg;

  localparam logic [1:0] ACT_PUSH       = 2'd0;
  localparam logic [1:0] ACT_POP        = 2'd1;
  localparam logic [1:0] ACT_POP_SIGNED = 2'd2;
  localparam logic [1:0] ACT_CLEAR      = 2'd3;

  localparam logic [5:0] MAX_BITS  = 6'd32;
  localparam logic [2:0] MAX_BYTES = 3'd5;

  typedef struct packed {
    logic load;
    logic wr;
    logic rd;
    logic finish;
  } cbf_cmd_t;

  typedef struct packed {
    logic do_write;
    logic do_read;
    logic last;
  } cbf_status_t;

  function automatic logic [31:0] low_mask(input logic [5:0] n);
    logic [32:0] m;
    m = (33'd1 << n) - 33'd1;
    return m[31:0];
  endfunction

endpackage

// ===== design/cbf_controller.sv =====
// Sequencing state machine for the circular bit FIFO.
module cbf_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  cbf_pkg::cbf_status_t status_i,
  output cbf_pkg::cbf_cmd_t    cmd_o
);
  import cbf_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_WRITE  = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.do_write) begin
          state_d = S_WRITE;
        end else if (status_i.do_read) begin
          state_d = S_READ;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_WRITE: begin
        cmd_o.wr = 1'b1;
        if (status_i.last) begin
          state_d = S_FINISH;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        if (status_i.last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/cbf_datapath.sv =====
// Byte store, bit pointers and word assembly for the circular bit FIFO.
module cbf_datapath #(
  parameter int STORE_BYTES = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cbf_pkg::cbf_cmd_t    cmd_i,
  output cbf_pkg::cbf_status_t status_o,
  input  logic [1:0]           action_i,
  input  logic [31:0]          push_data_i,
  input  logic [5:0]           bit_count_i,
  output logic                 ok_o,
  output logic [31:0]          pop_data_o,
  output logic [10:0]          stored_bits_o,
  output logic [10:0]          free_bits_o
);
  import cbf_pkg::*;

  localparam int IDX_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int PTR_W = IDX_W + 3;
  localparam int CW    = (PTR_W > 6) ? PTR_W : 6;
  localparam logic [PTR_W:0]   CAP      = (PTR_W + 1)'(STORE_BYTES * 8);
  localparam logic [PTR_W-1:0] FREE_MAX = PTR_W'(STORE_BYTES * 8 - 8);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(STORE_BYTES - 1);

  logic [7:0]       mem [STORE_BYTES];
  logic [7:0]       rdata_q;

  logic [PTR_W-1:0] rp_q, wp_q, cnt_q;
  logic [7:0]       tail_q;
  logic [1:0]       act_q;
  logic [5:0]       n_q;
  logic [2:0]       off_q;
  logic             ok_q;
  logic [39:0]      word_q;
  logic [IDX_W-1:0] idx_q;
  logic [2:0]       k_q, cap_q, nbytes_q;
  logic             rd_pend_q;
  logic             ok_out_q;
  logic [31:0]      pop_out_q;

  // load-time values
  logic [5:0]       n_sat;
  logic [2:0]       off_new;
  logic [PTR_W-1:0] ptr_sel;
  logic [PTR_W-1:0] free_now;
  logic             ok_new;
  logic [31:0]      data_m;
  logic [7:0]       tail_keep;
  logic [39:0]      word_new;
  logic [6:0]       span;

  // finish-time values
  logic [PTR_W:0]   wp_sum, rp_sum;
  logic [PTR_W-1:0] wp_next, rp_next;
  logic [39:0]      shifted;
  logic [31:0]      raw, mask_n, pop_val;
  logic             sign_bit;
  logic             is_pop;
  logic [IDX_W-1:0] idx_inc;

  always_comb begin
    n_sat     = (bit_count_i > MAX_BITS) ? MAX_BITS : bit_count_i;
    ptr_sel   = (action_i == ACT_PUSH) ? wp_q : rp_q;
    off_new   = ptr_sel[2:0];
    free_now  = FREE_MAX - cnt_q;
    case (action_i)
      ACT_PUSH:       ok_new = CW'(free_now) >= CW'(n_sat);
      ACT_POP:        ok_new = CW'(cnt_q) >= CW'(n_sat);
      ACT_POP_SIGNED: ok_new = CW'(cnt_q) >= CW'(n_sat);
      default:        ok_new = 1'b1;
    endcase
    data_m    = push_data_i & low_mask(n_sat);
    tail_keep = tail_q & (8'hFF >> (4'd8 - {1'b0, off_new}));
    word_new  = ({8'h00, data_m} << off_new) | {32'h0, tail_keep};
    span      = 7'({4'b0000, off_new} + {1'b0, n_sat} + 7'd7);
  end

  assign idx_inc = (idx_q == IDX_LAST) ? '0 : idx_q + IDX_W'(1);

  assign is_pop = (act_q == ACT_POP) || (act_q == ACT_POP_SIGNED);

  assign status_o.do_write = ok_q && (act_q == ACT_PUSH) && (nbytes_q != 3'd0);
  assign status_o.do_read  = ok_q && is_pop && (nbytes_q != 3'd0);
  assign status_o.last     = (k_q == nbytes_q - 3'd1);

  always_comb begin
    wp_sum   = {1'b0, wp_q} + (PTR_W + 1)'(n_q);
    rp_sum   = {1'b0, rp_q} + (PTR_W + 1)'(n_q);
    wp_next  = (wp_sum >= CAP) ? PTR_W'(wp_sum - CAP) : PTR_W'(wp_sum);
    rp_next  = (rp_sum >= CAP) ? PTR_W'(rp_sum - CAP) : PTR_W'(rp_sum);
    shifted  = word_q >> off_q;
    raw      = shifted[31:0];
    mask_n   = low_mask(n_q);
    sign_bit = raw[5'(n_q - 6'd1)];
    pop_val  = raw & mask_n;
    if ((act_q == ACT_POP_SIGNED) && (n_q != 6'd0) && (n_q < MAX_BITS) && sign_bit) begin
      pop_val = pop_val | ~mask_n;
    end
    if (!(ok_q && is_pop)) begin
      pop_val = 32'h0;
    end
  end

  // byte store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[idx_q] <= word_q[7:0];
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[idx_q];
    end
  end

  // item registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q    <= action_i;
      n_q      <= n_sat;
      off_q    <= off_new;
      word_q   <= word_new;
      idx_q    <= ptr_sel[PTR_W-1:3];
      nbytes_q <= span[5:3];
    end else begin
      if (cmd_i.wr) begin
        word_q <= word_q >> 8;
        tail_q <= word_q[7:0];
      end
      if (cmd_i.wr || cmd_i.rd) begin
        idx_q <= idx_inc;
      end
      if (rd_pend_q) begin
        for (int j = 0; j < 5; j++) begin
          if (cap_q == 3'(j)) begin
            word_q[8*j +: 8] <= rdata_q;
          end
        end
      end
    end
    if (cmd_i.finish) begin
      ok_out_q  <= ok_q;
      pop_out_q <= pop_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q      <= '0;
      wp_q      <= '0;
      cnt_q     <= '0;
      ok_q      <= 1'b0;
      k_q       <= '0;
      cap_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.rd;
      if (cmd_i.load) begin
        ok_q  <= ok_new;
        k_q   <= '0;
        cap_q <= '0;
      end else begin
        if (cmd_i.wr || cmd_i.rd) begin
          k_q <= k_q + 3'd1;
        end
        if (rd_pend_q) begin
          cap_q <= cap_q + 3'd1;
        end
      end
      if (cmd_i.finish) begin
        if (act_q == ACT_CLEAR) begin
          rp_q  <= '0;
          wp_q  <= '0;
          cnt_q <= '0;
        end else if (ok_q && act_q == ACT_PUSH) begin
          wp_q  <= wp_next;
          cnt_q <= cnt_q + PTR_W'(n_q);
        end else if (ok_q && is_pop) begin
          rp_q  <= rp_next;
          cnt_q <= cnt_q - PTR_W'(n_q);
        end
      end
    end
  end

  assign ok_o          = ok_out_q;
  assign pop_data_o    = pop_out_q;
  assign stored_bits_o = 11'(cnt_q);
  assign free_bits_o   = 11'(FREE_MAX - cnt_q);

`ifndef SYNTHESIS
  a_count_matches_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cnt_q} == (({1'b0, wp_q} >= {1'b0, rp_q}) ?
                       ({1'b0, wp_q} - {1'b0, rp_q}) :
                       (CAP + {1'b0, wp_q} - {1'b0, rp_q}))))
    else $error("stored count disagrees with bit pointers");

  a_byte_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr || cmd_i.rd) |-> (nbytes_q != 3'd0 && nbytes_q <= MAX_BYTES && k_q < nbytes_q))
    else $error("byte access outside item span");

  a_offset_from_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (off_q == ((act_q == ACT_PUSH) ? wp_q[2:0] : rp_q[2:0])))
    else $error("bit offset not taken from the active pointer");
`endif

endmodule

// ===== design/circular_bit_fifo.sv =====
// Top level of the circular bit FIFO: controller and datapath.
// Sequence, accept to result valid: load, exec, byte writes (push) or reads
//   and drain (pop), then finish into the result register. Clear, refused or
//   zero count on a byte boundary touch no byte; an item spans at most 5 bytes.
// Throughput: one store byte per cycle; the input stalls until finish.
// Reset: pointers and stored count clear at once; byte store holds garbage
//   until pushed, and needs no clearing pass.
module circular_bit_fifo #(
  parameter int STORE_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] push_data_i,
  input  logic [5:0]  bit_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic [31:0] pop_data_o,
  output logic [10:0] stored_bits_o,
  output logic [10:0] free_bits_o
);
  import cbf_pkg::*;

  // Commands flow controller -> datapath, status flows back.
  cbf_cmd_t    cmd;
  cbf_status_t status;

  // Sequence each transaction: load, byte writes or reads, then finish.
  cbf_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold the byte store, pointers and the result register; the result
  // register lets the output wait on a stall without blocking the next load.
  cbf_datapath #(
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .action_i      (action_i),
    .push_data_i   (push_data_i),
    .bit_count_i   (bit_count_i),
    .ok_o          (ok_o),
    .pop_data_o    (pop_data_o),
    .stored_bits_o (stored_bits_o),
    .free_bits_o   (free_bits_o)
  );

endmodule
